[rtl/core/olpe_pkg.sv]
// Shared types and codes for the ordered list position engine.
// Holds the transaction codes, status codes and the cell control bundle.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package olpe_pkg;

    localparam int KIND_W    = 2;
    localparam int POS_W     = 7;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;
    localparam int DEPTH_DEF = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_INS  = 2'd1;
    localparam logic [1:0] CELL_DEL  = 2'd2;
    localparam logic [1:0] CELL_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic [POS_W-1:0]        at;
        logic [POS_W-1:0]        len;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/core/olpe_cell.sv]
// One storage cell of the list chain, holding the entry at a fixed position.
// Shifts toward the tail on insert, toward the head on delete, and rotates
// during a traverse. Depends on olpe_pkg.
`default_nettype none

module olpe_cell #(
    parameter int IDX = 0
) (
    input  wire                               i_clk,
    input  wire olpe_pkg::t_cell_ctl          i_ctl,
    input  wire signed [olpe_pkg::DATA_W-1:0] i_left,
    input  wire signed [olpe_pkg::DATA_W-1:0] i_right,
    input  wire signed [olpe_pkg::DATA_W-1:0] i_head,
    output logic signed [olpe_pkg::DATA_W-1:0] o_value
);
    import olpe_pkg::*;

    localparam logic [POS_W-1:0] C_IDX  = POS_W'(IDX);
    localparam logic [POS_W-1:0] C_NEXT = POS_W'(IDX + 1);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            CELL_INS: begin
                if (C_IDX > i_ctl.at) begin
                    n_value = i_left;
                end else if (C_IDX == i_ctl.at) begin
                    n_value = i_ctl.data;
                end
            end
            CELL_DEL: begin
                if (C_IDX >= i_ctl.at) begin
                    n_value = i_right;
                end
            end
            CELL_ROT: begin
                if (C_NEXT == i_ctl.len) begin
                    n_value = i_head;
                end else begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

[rtl/core/ordered_list_position_engine.sv]
// Top level of the ordered list position engine: control and the cell chain.
// Instantiates olpe_cell once per list position; depends on olpe_pkg.
//
// Usage: one input channel (i_valid, o_stall, i_kind, i_position, i_value)
// and one result channel (o_valid, i_stall, o_value_res, o_last, o_status).
// A transaction moves on a channel at a rising edge with valid high and
// stall low. Insert and delete give one result, registered as the transaction
// is taken; the list change is made in that same cycle by all cells shifting
// at once, so a new transaction can follow in the next cycle as long as the
// receiver takes the result from the output register.
// A traverse gives one result per stored entry, one per cycle while the
// receiver takes them, head first, with o_last on the tail entry; the chain
// rotates by one cell per result and is back in order after the last. An
// empty list gives one result with status empty. The input is stalled for
// the length of a traverse.
// Unused kind codes are taken and give no result.
// Reset empties the list; cell contents are not cleared. When the receiver
// stalls, the output register holds and the input stalls in turn.
`default_nettype none

module ordered_list_position_engine #(
    parameter int DEPTH = olpe_pkg::DEPTH_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire [olpe_pkg::KIND_W-1:0]         i_kind,
    input  wire [olpe_pkg::POS_W-1:0]          i_position,
    input  wire signed [olpe_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic signed [olpe_pkg::DATA_W-1:0] o_value_res,
    output logic                               o_last,
    output logic [olpe_pkg::STAT_W-1:0]        o_status
);
    import olpe_pkg::*;

    localparam int LW = $clog2(DEPTH + 1);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_TRAV = 1'b1;

    logic                     r_state;
    logic                     n_state;
    logic [LW-1:0]            r_len;
    logic [LW-1:0]            n_len;
    logic [LW-1:0]            r_cnt;
    logic [LW-1:0]            n_cnt;
    logic                     r_ovalid;
    logic                     n_ovalid;
    logic signed [DATA_W-1:0] r_oval;
    logic signed [DATA_W-1:0] n_oval;
    logic                     r_olast;
    logic                     n_olast;
    logic [STAT_W-1:0]        r_ostat;
    logic [STAT_W-1:0]        n_ostat;

    t_cell_ctl                w_ctl;
    logic signed [DATA_W-1:0] w_val   [DEPTH];
    logic signed [DATA_W-1:0] w_left  [DEPTH];
    logic signed [DATA_W-1:0] w_right [DEPTH];

    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_cnt_last;
    logic [POS_W-1:0]         w_len_ext;
    logic [POS_W-1:0]         w_pos_m1;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign w_full     = (r_len == LW'(DEPTH));
    assign w_cnt_last = (r_cnt == (r_len - LW'(1)));
    assign w_len_ext  = POS_W'(r_len);
    assign w_pos_m1   = i_position - POS_W'(1);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_oval   = r_oval;
        n_olast  = r_olast;
        n_ostat  = r_ostat;
        w_ctl.op   = CELL_HOLD;
        w_ctl.at   = '0;
        w_ctl.len  = w_len_ext;
        w_ctl.data = i_value;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        KIND_INSERT: begin
                            n_ovalid = 1'b1;
                            n_oval   = '0;
                            n_olast  = 1'b1;
                            if (w_full) begin
                                n_ostat = STAT_FULL;
                            end else if (i_position == '0) begin
                                n_ostat = STAT_BADPOS;
                            end else begin
                                n_ostat  = STAT_OK;
                                w_ctl.op = CELL_INS;
                                w_ctl.at = (w_pos_m1 > w_len_ext) ? w_len_ext : w_pos_m1;
                                n_len    = r_len + LW'(1);
                            end
                        end
                        KIND_DELETE: begin
                            n_ovalid = 1'b1;
                            n_oval   = '0;
                            n_olast  = 1'b1;
                            if (r_len == '0) begin
                                n_ostat = STAT_EMPTY;
                            end else if ((i_position == '0) || (i_position > w_len_ext)) begin
                                n_ostat = STAT_BADPOS;
                            end else begin
                                n_ostat  = STAT_OK;
                                w_ctl.op = CELL_DEL;
                                w_ctl.at = w_pos_m1;
                                n_len    = r_len - LW'(1);
                            end
                        end
                        KIND_TRAVERSE: begin
                            if (r_len == '0) begin
                                n_ovalid = 1'b1;
                                n_oval   = '0;
                                n_olast  = 1'b1;
                                n_ostat  = STAT_EMPTY;
                            end else begin
                                n_state = S_TRAV;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_TRAV: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oval   = w_val[0];
                    n_olast  = w_cnt_last;
                    n_ostat  = STAT_OK;
                    w_ctl.op = CELL_ROT;
                    n_cnt    = r_cnt + LW'(1);
                    if (w_cnt_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

    assign o_valid     = r_ovalid;
    assign o_value_res = r_oval;
    assign o_last      = r_olast;
    assign o_status    = r_ostat;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = '0;
        end else begin : g_inner_l
            assign w_left[g] = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_final
            assign w_right[g] = '0;
        end else begin : g_inner_r
            assign w_right[g] = w_val[g+1];
        end
        olpe_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_left (w_left[g]),
            .i_right(w_right[g]),
            .i_head (w_val[0]),
            .o_value(w_val[g])
        );
    end

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(DEPTH))
        else $error("List length exceeds the chain depth.");

    a_trav_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAV) |-> o_stall)
        else $error("Input taken during a traverse.");

    a_trav_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRAV) |-> (r_cnt < r_len) && (r_len != '0))
        else $error("Traverse counter out of range.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_kind == KIND_INSERT) && !w_full && (i_position != '0))
        |=> (r_len == $past(r_len) + LW'(1)))
        else $error("Accepted insert did not grow the list.");
`endif

endmodule

`default_nettype wire

[tb/sv/ordered_list_position_engine_chk.sv]
// Checker for the ordered list position engine: watches both channels,
// predicts each result from its own copy of the list and compares in order.
// Depends on olpe_pkg for widths, transaction kinds and status codes.
`timescale 1ns / 1ps

module ordered_list_position_engine_chk (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_req_valid,
    input  wire                                i_req_stall,
    input  wire [olpe_pkg::KIND_W-1:0]         i_req_kind,
    input  wire [olpe_pkg::POS_W-1:0]          i_req_position,
    input  wire signed [olpe_pkg::DATA_W-1:0]  i_req_value,
    input  wire                                i_res_valid,
    input  wire                                i_res_stall,
    input  wire signed [olpe_pkg::DATA_W-1:0]  i_res_value,
    input  wire                                i_res_last,
    input  wire [olpe_pkg::STAT_W-1:0]         i_res_status,
    output int                                 o_mismatches,
    output int                                 o_outstanding
);
    import olpe_pkg::*;

    localparam int LIST_CAP = DEPTH_DEF;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic [STAT_W-1:0]        status;
    } t_list_result;

    logic signed [DATA_W-1:0] shadow_list[$];
    t_list_result             results_due[$];

    task automatic queue_status(input logic [STAT_W-1:0] st);
        t_list_result r;
        r.value  = '0;
        r.last   = 1'b1;
        r.status = st;
        results_due.push_back(r);
    endtask

    task automatic predict_list_op(input logic [KIND_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] val);
        int           at;
        t_list_result r;
        case (kind)
            KIND_INSERT: begin
                if (shadow_list.size() >= LIST_CAP) begin
                    queue_status(STAT_FULL);
                end else if (pos == 0) begin
                    queue_status(STAT_BADPOS);
                end else begin
                    at = int'(pos) - 1;
                    if (at > shadow_list.size())
                        at = shadow_list.size();
                    shadow_list.insert(at, val);
                    queue_status(STAT_OK);
                end
            end
            KIND_DELETE: begin
                if (shadow_list.size() == 0) begin
                    queue_status(STAT_EMPTY);
                end else if (pos == 0 || int'(pos) > shadow_list.size()) begin
                    queue_status(STAT_BADPOS);
                end else begin
                    shadow_list.delete(int'(pos) - 1);
                    queue_status(STAT_OK);
                end
            end
            KIND_TRAVERSE: begin
                if (shadow_list.size() == 0) begin
                    queue_status(STAT_EMPTY);
                end else begin
                    for (int i = 0; i < shadow_list.size(); i++) begin
                        r.value  = shadow_list[i];
                        r.last   = (i == shadow_list.size() - 1);
                        r.status = STAT_OK;
                        results_due.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Results are compared before the new transaction is modeled, since a
    // result never leaves in the same cycle its transaction is taken.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            shadow_list.delete();
            results_due.delete();
            o_mismatches = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual value %0d last %0b status %0d",
                             $time, i_res_value, i_res_last, i_res_status);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = results_due.pop_front();
                    if (i_res_value !== want.value) begin
                        $display("%0t: value mismatch: expected %0d, actual %0d",
                                 $time, want.value, i_res_value);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (i_res_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, i_res_last);
                        o_mismatches = o_mismatches + 1;
                    end
                    if (i_res_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_res_status);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                predict_list_op(i_req_kind, i_req_position, i_req_value);
        end
        o_outstanding = results_due.size();
    end

endmodule

[tb/sv/ordered_list_position_engine_tb.sv]
// Testbench top for the ordered list position engine: clock, reset, stimulus,
// random idling on both channels, watchdog and the final verdict.
// Depends on olpe_pkg, the engine RTL and ordered_list_position_engine_chk.
`timescale 1ns / 1ps

module ordered_list_position_engine_tb;
    import olpe_pkg::*;

    localparam int RANDOM_ITEMS = 425;
    localparam int PHASE_ITEMS  = 60;
    localparam int QUIET_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic [KIND_W-1:0]        i_kind     = KIND_TRAVERSE;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     i_stall    = 1'b0;
    logic                     o_stall;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_value_res;
    logic                     o_last;
    logic [STAT_W-1:0]        o_status;

    int   mismatches;
    int   outstanding;
    logic req_taken   = 1'b0;
    bit   calm        = 1'b0;
    int   stall_hold  = 0;
    int   quiet_cycles = 0;
    int   list_fill   = 0;

    ordered_list_position_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_res (o_value_res),
        .o_last      (o_last),
        .o_status    (o_status)
    );

    ordered_list_position_engine_chk checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_req_kind     (i_kind),
        .i_req_position (i_position),
        .i_req_value    (i_value),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_res_value    (o_value_res),
        .i_res_last     (o_last),
        .i_res_status   (o_status),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        int r;
        if (calm) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                i_stall    <= 1'b0;
                stall_hold <= $urandom_range(0, 30);
            end else if (r < 90) begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(0, 3);
            end else begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] kind,
                             input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind     = kind;
        i_position = pos;
        i_value    = val;
        i_valid    = 1'b1;
        do @(negedge i_clk); while (!req_taken);
        if (kind == KIND_INSERT && pos != 0 && list_fill < DEPTH_DEF)
            list_fill++;
        else if (kind == KIND_DELETE && pos != 0 && int'(pos) <= list_fill)
            list_fill--;
    endtask

    initial begin
        int                       sent;
        int                       in_phase;
        int                       r;
        bit                       filling;
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(KIND_TRAVERSE, 7'd0, 32'sd0);
        send_item(KIND_DELETE, 7'd1, 32'sd0);
        send_item(KIND_DELETE, 7'd0, 32'sd0);
        send_item(KIND_INSERT, 7'd0, 32'sd5);
        send_item(KIND_INSERT, 7'd1, 32'sh7FFFFFFF);
        send_item(KIND_INSERT, 7'd127, 32'sh80000000);
        send_item(KIND_INSERT, 7'd1, -32'sd1);
        send_item(KIND_INSERT, 7'd2, 32'sd0);
        send_item(KIND_TRAVERSE, 7'd127, -32'sd1);
        send_item(KIND_DELETE, 7'd0, 32'sd0);
        send_item(KIND_DELETE, 7'd5, 32'sd0);
        send_item(KIND_DELETE, 7'd127, -32'sd1);
        send_item(KIND_SPARE, 7'd127, -32'sd1);
        send_item(KIND_DELETE, 7'd4, 32'sd0);
        send_item(KIND_DELETE, 7'd1, 32'sd0);
        send_item(KIND_TRAVERSE, 7'd0, 32'sd0);
        send_item(KIND_DELETE, 7'd1, 32'sd0);
        send_item(KIND_DELETE, 7'd1, 32'sd0);
        send_item(KIND_TRAVERSE, 7'd64, 32'sd0);

        // Alternate filling and draining so the list swings between empty
        // and full; every third phase runs without idling on either side.
        sent = 0;
        for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
            calm     = (phase % 3 == 2);
            filling  = (phase % 2 == 0);
            in_phase = 0;
            while (in_phase < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < (filling ? 70 : 10))
                    kind = KIND_INSERT;
                else if (r < 80)
                    kind = KIND_DELETE;
                else if (r < 96)
                    kind = KIND_TRAVERSE;
                else
                    kind = KIND_SPARE;
                r = $urandom_range(0, 99);
                if (r < 80 && kind == KIND_DELETE)
                    pos = POS_W'($urandom_range(1, (list_fill > 0) ? list_fill : 1));
                else if (r < 80)
                    pos = POS_W'($urandom_range(1, list_fill + 1));
                else if (r < 88)
                    pos = '0;
                else
                    pos = POS_W'($urandom_range(0, 127));
                r = $urandom_range(0, 99);
                if (r < 10)
                    val = 32'sh7FFFFFFF;
                else if (r < 20)
                    val = 32'sh80000000;
                else
                    val = $urandom;
                send_item(kind, pos, val);
                if (kind != KIND_SPARE) begin
                    in_phase++;
                    sent++;
                end
            end
        end

        i_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
